[src/awhd_pkg.sv]
// awhd_pkg: shared constants and types of the alpha weighted half downsampler
`timescale 1ns / 1ps
`default_nettype none
package awhd_pkg;

  // configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 1'b1;

  // pixel channels and divider
  localparam int PIX_W = 8;
  localparam int QUO_W = 8;

  // per-axis footprint flags of the current source texel
  typedef struct packed {
    logic two;       // texel straddles two output texels
    logic first_lo;  // texel opens the lower output footprint
    logic last_lo;   // texel closes the lower output footprint
    logic end_pos;   // last texel of the axis
    logic last_out;  // lower output is the last output of the axis
  } axis_flags_t;

endpackage
`default_nettype wire

[src/awhd_if.sv]
// awhd_if: valid/ready channels for source pixels and output texels
`timescale 1ns / 1ps
`default_nettype none
interface awhd_src_if import awhd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] src_red;
  logic [PIX_W-1:0] src_green;
  logic [PIX_W-1:0] src_blue;
  logic [PIX_W-1:0] src_alpha;
  modport source (output valid, src_red, src_green, src_blue, src_alpha, input ready);
  modport sink (input valid, src_red, src_green, src_blue, src_alpha, output ready);
endinterface

interface awhd_dst_if import awhd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;
  logic [PIX_W-1:0] out_alpha;
  logic             frame_last;
  modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_last,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, frame_last,
                output ready);
endinterface
`default_nettype wire

[src/alpha_weighted_half_downsample.sv]
// alpha_weighted_half_downsample: top level, mip level downsampler with line sum memories
// a pixel is taken only in the idle state, after the last one is done: each of up to
// four touched sums takes a read, two multiply stages and a write on the shared sum memories
// a pixel that closes a footprint adds a serial division and a load into the output
// register; the next pixel is taken while the loaded word waits there for the sink
// synchronous reset clears position, sizes (to 1) and handshake state; sum memories
// need no clearing since the first pixel of each footprint overwrites its entry
`timescale 1ns / 1ps
`default_nettype none
module alpha_weighted_half_downsample import awhd_pkg::*; #(
  parameter int MAX_SOURCE_WIDTH  = 4096,
  parameter int MAX_SOURCE_HEIGHT = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  awhd_src_if.sink                  src,
  awhd_dst_if.source                dst
);

  localparam int NBX  = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int NBY  = $clog2(MAX_SOURCE_HEIGHT + 1);
  localparam int HALF_COLS = MAX_SOURCE_WIDTH / 2;
  localparam int HALF_ROWS = MAX_SOURCE_HEIGHT / 2;
  localparam int OBX  = (HALF_COLS > 1) ? $clog2(HALF_COLS) : 1;
  localparam int OBY  = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
  localparam int DEPTH = 2 * HALF_COLS;
  localparam int AB   = $clog2(DEPTH);
  localparam int AW   = $clog2(longint'(255) * longint'(MAX_SOURCE_WIDTH) *
                               longint'(MAX_SOURCE_HEIGHT) + longint'(1));
  localparam int CW   = $clog2(longint'(65025) * longint'(MAX_SOURCE_WIDTH) *
                               longint'(MAX_SOURCE_HEIGHT) + longint'(1));
  localparam int ARB  = $clog2(longint'(MAX_SOURCE_WIDTH) *
                               longint'(MAX_SOURCE_HEIGHT) + longint'(1));
  localparam int WB   = (NBX > NBY) ? NBX : NBY;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_PROD = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]       state;
  logic [CFG_W-1:0] source_width;
  logic [CFG_W-1:0] source_height;
  logic [ARB-1:0]   area;
  logic             accept;

  // axis trackers
  logic [OBX-1:0] col_lo;
  logic [OBY-1:0] row_lo;
  logic [NBX-1:0] col_wt_lo, col_wt_hi;
  logic [NBY-1:0] row_wt_lo, row_wt_hi;
  axis_flags_t    col_flags, row_flags;

  // latched pixel
  logic [PIX_W-1:0] px_r, px_g, px_b, px_a;
  logic [WB-1:0]    wx_lo, wx_hi, wy_lo, wy_hi;
  logic [OBX-1:0]   ox_lo;
  logic             oy_lo0;
  logic             tx, ty, fx_lo, fy_lo, lx_lo, ly_lo, last_px;

  // operation state
  logic [1:0]       op;
  logic [1:0]       op_nxt;
  logic             op_more;
  logic [WB-1:0]    op_wx, op_wy;
  logic             op_first, op_emit;
  logic [OBX-1:0]   op_ox;
  logic             op_oy0;
  logic [AB-1:0]    op_addr;
  logic [2*WB-1:0]  wxy;
  logic [AW-1:0]    wa;
  logic [CW-1:0]    cp_r, cp_g, cp_b;
  logic [AW-1:0]    rd_a;
  logic [3*CW-1:0]  rd_c;
  logic [AW-1:0]    new_a;
  logic [3*CW-1:0]  new_c;
  logic             ram_re, ram_we;

  // emission
  logic             emit_pend;
  logic             frame_last_r;
  logic [AW-1:0]    as_e;
  logic [CW-1:0]    cs_r, cs_g, cs_b;
  logic             emit_now;
  logic [AW-1:0]    as_d;
  logic [CW-1:0]    cs_r_d, cs_g_d, cs_b_d;
  logic             div_start;
  logic             busy_r, busy_g, busy_b, busy_a;
  logic [QUO_W-1:0] q_r, q_g, q_b, q_a;
  logic             out_load;

  assign accept    = src.valid && src.ready;
  assign src.ready = state == S_IDLE;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= CFG_W'(1);
      source_height <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        REG_SOURCE_HEIGHT: source_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // footprint trackers, row steps when the column wraps
  awhd_axis #(.MAX_N(MAX_SOURCE_WIDTH)) u_col (
    .clk(clk), .rst(rst), .restart(cfg_we), .advance(accept), .size_cfg(source_width),
    .lo(col_lo), .wt_lo(col_wt_lo), .wt_hi(col_wt_hi), .flags(col_flags)
  );

  awhd_axis #(.MAX_N(MAX_SOURCE_HEIGHT)) u_row (
    .clk(clk), .rst(rst), .restart(cfg_we), .advance(accept && col_flags.end_pos),
    .size_cfg(source_height),
    .lo(row_lo), .wt_lo(row_wt_lo), .wt_hi(row_wt_hi), .flags(row_flags)
  );

  // image area from clamped sizes
  always_ff @(posedge clk) begin
    logic [31:0] wc, hc;
    wc = 32'(source_width);
    hc = 32'(source_height);
    if (wc == 32'd0) wc = 32'd1;
    if (wc > 32'(MAX_SOURCE_WIDTH)) wc = 32'(MAX_SOURCE_WIDTH);
    if (hc == 32'd0) hc = 32'd1;
    if (hc > 32'(MAX_SOURCE_HEIGHT)) hc = 32'(MAX_SOURCE_HEIGHT);
    area <= ARB'(NBX'(wc)) * ARB'(NBY'(hc));
  end

  // latch pixel and its footprint on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r    <= src.src_red;
      px_g    <= src.src_green;
      px_b    <= src.src_blue;
      px_a    <= src.src_alpha;
      wx_lo   <= WB'(col_wt_lo);
      wx_hi   <= WB'(col_wt_hi);
      wy_lo   <= WB'(row_wt_lo);
      wy_hi   <= WB'(row_wt_hi);
      ox_lo   <= col_lo;
      oy_lo0  <= row_lo[0];
      tx      <= col_flags.two;
      ty      <= row_flags.two;
      fx_lo   <= col_flags.first_lo;
      fy_lo   <= row_flags.first_lo;
      lx_lo   <= col_flags.last_lo;
      ly_lo   <= row_flags.last_lo;
      last_px <= col_flags.last_out && row_flags.last_out;
    end
  end

  // current update: op bit 0 picks the column, bit 1 the row
  always_comb begin
    op_wx    = op[0] ? wx_hi : wx_lo;
    op_wy    = op[1] ? wy_hi : wy_lo;
    op_first = (op[0] || fx_lo) && (op[1] || fy_lo);
    op_emit  = (op == 2'd0) && lx_lo && ly_lo;
    op_ox    = op[0] ? ox_lo + OBX'(1) : ox_lo;
    op_oy0   = op[1] ? !oy_lo0 : oy_lo0;
    op_addr  = AB'(op_ox) + (op_oy0 ? AB'(HALF_COLS) : AB'(0));
    op_more  = 1'b0;
    op_nxt   = op;
    case (op)
      2'd0: begin
        op_more = tx || ty;
        op_nxt  = tx ? 2'd1 : 2'd2;
      end
      2'd1: begin
        op_more = ty;
        op_nxt  = 2'd2;
      end
      2'd2: begin
        op_more = tx;
        op_nxt  = 2'd3;
      end
      default: begin
        op_more = 1'b0;
        op_nxt  = op;
      end
    endcase
  end

  // multiply stages: weight area, alpha weight, per-channel products
  always_ff @(posedge clk) begin
    if (state == S_RD) begin
      wxy <= op_wx * op_wy;
    end
    if (state == S_MUL) begin
      wa <= AW'(wxy) * AW'(px_a);
    end
    if (state == S_PROD) begin
      cp_r <= CW'(wa) * CW'(px_r);
      cp_g <= CW'(wa) * CW'(px_g);
      cp_b <= CW'(wa) * CW'(px_b);
    end
  end

  // read-modify-write of the sums
  assign ram_re = state == S_RD;
  assign ram_we = state == S_WR;

  always_comb begin
    if (op_first) begin
      new_a = wa;
      new_c = {cp_b, cp_g, cp_r};
    end else begin
      new_a = rd_a + wa;
      new_c = {rd_c[3*CW-1:2*CW] + cp_b, rd_c[2*CW-1:CW] + cp_g, rd_c[CW-1:0] + cp_r};
    end
  end

  awhd_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_alpha_ram (
    .clk(clk), .we(ram_we), .waddr(op_addr), .wdata(new_a),
    .re(ram_re), .raddr(op_addr), .rdata(rd_a)
  );

  awhd_ram #(.WIDTH(3 * CW), .DEPTH(DEPTH)) u_color_ram (
    .clk(clk), .we(ram_we), .waddr(op_addr), .wdata(new_c),
    .re(ram_re), .raddr(op_addr), .rdata(rd_c)
  );

  // sequencer
  assign div_start = (state == S_WR) && !op_more && (emit_pend || op_emit);
  assign out_load  = (state == S_DONE) && (!dst.valid || dst.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= 2'd0;
      emit_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= 2'd0;
            state <= S_RD;
          end
        end
        S_RD:   state <= S_MUL;
        S_MUL:  state <= S_PROD;
        S_PROD: state <= S_WR;
        S_WR: begin
          if (op_emit) begin
            emit_pend <= 1'b1;
          end
          if (op_more) begin
            op    <= op_nxt;
            state <= S_RD;
          end else if (div_start) begin
            state <= S_DIV;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (!busy_a) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            emit_pend <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // closing sums of the emitted texel
  always_ff @(posedge clk) begin
    if (state == S_WR && op_emit) begin
      as_e         <= new_a;
      cs_r         <= new_c[CW-1:0];
      cs_g         <= new_c[2*CW-1:CW];
      cs_b         <= new_c[3*CW-1:2*CW];
      frame_last_r <= last_px;
    end
  end

  // divider operands, straight from the write when the texel closes in this step
  assign emit_now = (state == S_WR) && op_emit;
  assign as_d     = emit_now ? new_a : as_e;
  assign cs_r_d   = emit_now ? new_c[CW-1:0] : cs_r;
  assign cs_g_d   = emit_now ? new_c[2*CW-1:CW] : cs_g;
  assign cs_b_d   = emit_now ? new_c[3*CW-1:2*CW] : cs_b;

  // rounded means: (sum + den/2) / den
  awhd_div #(.W(CW + 1)) u_div_r (
    .clk(clk), .rst(rst), .start(div_start),
    .num((CW + 1)'(cs_r_d) + (CW + 1)'(as_d >> 1)), .den((CW + 1)'(as_d)),
    .busy(busy_r), .quo(q_r)
  );

  awhd_div #(.W(CW + 1)) u_div_g (
    .clk(clk), .rst(rst), .start(div_start),
    .num((CW + 1)'(cs_g_d) + (CW + 1)'(as_d >> 1)), .den((CW + 1)'(as_d)),
    .busy(busy_g), .quo(q_g)
  );

  awhd_div #(.W(CW + 1)) u_div_b (
    .clk(clk), .rst(rst), .start(div_start),
    .num((CW + 1)'(cs_b_d) + (CW + 1)'(as_d >> 1)), .den((CW + 1)'(as_d)),
    .busy(busy_b), .quo(q_b)
  );

  awhd_div #(.W(AW + 1)) u_div_a (
    .clk(clk), .rst(rst), .start(div_start),
    .num((AW + 1)'(as_d) + (AW + 1)'(area >> 1)), .den((AW + 1)'(area)),
    .busy(busy_a), .quo(q_a)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst.valid <= 1'b0;
    end else if (out_load) begin
      dst.valid <= 1'b1;
    end else if (dst.ready) begin
      dst.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      dst.out_red    <= (as_e == '0) ? '0 : q_r;
      dst.out_green  <= (as_e == '0) ? '0 : q_g;
      dst.out_blue   <= (as_e == '0) ? '0 : q_b;
      dst.out_alpha  <= q_a;
      dst.frame_last <= frame_last_r;
    end
  end

  // checks
  assert property (@(posedge clk) disable iff (rst) (state == S_DIV) |-> emit_pend)
    else $error("divide without pending texel");
  assert property (@(posedge clk) disable iff (rst)
    src.ready |-> !(busy_r || busy_g || busy_b || busy_a))
    else $error("pixel taken while dividers busy");
  assert property (@(posedge clk) disable iff (rst) div_start |=> busy_a && busy_r)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst) (state == S_DONE) |-> !busy_a)
    else $error("result loaded before divide finished");

endmodule
`default_nettype wire

[src/awhd_ram.sv]
// awhd_ram: generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module awhd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AB = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AB-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AB-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[src/awhd_axis.sv]
// awhd_axis: incremental footprint tracker for one image axis
`timescale 1ns / 1ps
`default_nettype none
module awhd_axis import awhd_pkg::*; #(
  parameter int MAX_N = 4096,
  localparam int NB = $clog2(MAX_N + 1),
  localparam int HALF = MAX_N / 2,
  localparam int OB = (HALF > 1) ? $clog2(HALF) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             restart,
  input  wire logic             advance,
  input  wire logic [CFG_W-1:0] size_cfg,
  output logic      [OB-1:0]    lo,
  output logic      [NB-1:0]    wt_lo,
  output logic      [NB-1:0]    wt_hi,
  output axis_flags_t           flags
);

  logic [NB-1:0] pos;
  logic [NB-1:0] rem;
  logic [NB-1:0] n;
  logic [NB-1:0] d;
  logic [NB:0]   sum;
  logic [NB-1:0] n_minus;
  logic [31:0]   size32;

  // clamp size to 1..MAX_N, destination is half (at least 1)
  always_comb begin
    size32 = 32'(size_cfg);
    if (size32 == 32'd0) begin
      n = NB'(1);
    end else if (size32 > 32'(MAX_N)) begin
      n = NB'(MAX_N);
    end else begin
      n = NB'(size32);
    end
    d = (n > NB'(1)) ? (n >> 1) : NB'(1);
  end

  // overlap of texel [pos*d, pos*d+d) with outputs lo and lo+1
  always_comb begin
    sum            = {1'b0, rem} + {1'b0, d};
    n_minus        = n - rem;
    wt_lo          = (n_minus < d) ? n_minus : d;
    wt_hi          = NB'(sum - {1'b0, n});
    flags.two      = sum > {1'b0, n};
    flags.first_lo = rem == '0;
    flags.last_lo  = n_minus <= d;
    flags.end_pos  = pos == (n - NB'(1));
    flags.last_out = NB'(lo) == (d - NB'(1));
  end

  // position, output index and remainder step
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pos <= '0;
      rem <= '0;
      lo  <= '0;
    end else if (advance) begin
      if (flags.end_pos) begin
        pos <= '0;
        rem <= '0;
        lo  <= '0;
      end else begin
        pos <= pos + NB'(1);
        if (sum >= {1'b0, n}) begin
          rem <= NB'(sum - {1'b0, n});
          lo  <= lo + OB'(1);
        end else begin
          rem <= NB'(sum);
        end
      end
    end
  end

endmodule
`default_nettype wire

[src/awhd_div.sv]
// awhd_div: restoring divider, one quotient bit per cycle, 8-bit quotient
`timescale 1ns / 1ps
`default_nettype none
module awhd_div import awhd_pkg::*; #(
  parameter int W = 41,
  localparam int CB = $clog2(QUO_W)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [W-1:0]     num,
  input  wire logic [W-1:0]     den,
  output logic                  busy,
  output logic      [QUO_W-1:0] quo
);

  logic [W-1:0]   rem;
  logic [W+7:0]   dsh;
  logic [CB-1:0]  cnt;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CB'(1);
      if (cnt == CB'(QUO_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // compare and subtract, divisor moves right one bit a step
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= (W + 8)'(den) << (QUO_W - 1);
      quo <= '0;
    end else if (busy) begin
      dsh <= dsh >> 1;
      if (dsh <= (W + 8)'(rem)) begin
        rem <= rem - W'(dsh);
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

[test/tb_alpha_weighted_half_downsample.sv]
// tb_alpha_weighted_half_downsample: self-checking testbench of the mip level downsampler
`timescale 1ns / 1ps
module tb_alpha_weighted_half_downsample;
  import awhd_pkg::*;

  localparam int MAX_W      = 4096;
  localparam int MAX_H      = 4096;
  localparam int HALF_COLS  = MAX_W / 2;
  localparam int SETTLE     = 40;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
  } texel_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
    logic             last;
  } mip_word_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  awhd_src_if src_ch ();
  awhd_dst_if dst_ch ();

  alpha_weighted_half_downsample uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src       (src_ch),
    .dst       (dst_ch)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  texel_t    pixel_q[$];
  mip_word_t texel_q[$];
  int        mismatches = 0;
  bit        idle_en = 1'b1;
  bit        src_fire = 1'b0;
  int        src_gap = 0;
  int        dst_gap = 0;
  int        quiet_cycles = 0;

  // downsampler shadow state
  longint unsigned alpha_acc [2*HALF_COLS];
  longint unsigned color_acc [6*HALF_COLS];
  int unsigned     width_reg = 1;
  int unsigned     height_reg = 1;
  int unsigned     col_pos = 0;
  int unsigned     row_pos = 0;
  int unsigned     bank_sel = 0;

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned mx);
    if (v < 1) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  // output texels covered by source texel s on one axis
  function automatic int footprint(input int unsigned s, input int unsigned n,
                                   input int unsigned d, output int unsigned o[2],
                                   output longint unsigned wt[2], output bit fst[2],
                                   output bit lst[2]);
    longint unsigned tl, th, ol, orr, a, b;
    int unsigned lo, hi, oo;
    int cnt;
    tl = longint'(s) * d;
    th = tl + d;
    lo = 32'(tl / n);
    hi = 32'((th - 1) / n);
    cnt = (hi != lo) ? 2 : 1;
    for (int i = 0; i < cnt; i++) begin
      oo = i ? hi : lo;
      ol = longint'(oo) * n;
      orr = ol + n;
      a = ol > tl ? ol : tl;
      b = orr < th ? orr : th;
      o[i] = oo;
      wt[i] = b - a;
      fst[i] = (ol / d) == s;
      lst[i] = ((orr - 1) / d) == s;
    end
    return cnt;
  endfunction

  // accumulate one source pixel, queue the texel it completes
  task automatic accumulate_pixel(input texel_t p);
    int unsigned w, h, dw, dh, bank, idx;
    int unsigned ox[2], oy[2];
    longint unsigned wx[2], wy[2], wa, asum, area, csum;
    longint unsigned ch[3];
    longint unsigned q[3];
    bit fx[2], lx[2], fy[2], ly[2];
    bit emitted;
    int nx, ny;
    mip_word_t word;
    w = clamp_size(width_reg, MAX_W);
    h = clamp_size(height_reg, MAX_H);
    dw = w > 1 ? w >> 1 : 1;
    dh = h > 1 ? h >> 1 : 1;
    ch[0] = p.red;
    ch[1] = p.green;
    ch[2] = p.blue;
    emitted = 1'b0;
    if (col_pos >= w || row_pos >= h) begin
      col_pos = 0;
      row_pos = 0;
      bank_sel = 0;
    end
    nx = footprint(col_pos, w, dw, ox, wx, fx, lx);
    ny = footprint(row_pos, h, dh, oy, wy, fy, ly);
    for (int j = 0; j < ny; j++) begin
      bank = (bank_sel ^ j) & 1;
      for (int i = 0; i < nx; i++) begin
        idx = bank * HALF_COLS + ox[i];
        wa = wx[i] * wy[j] * p.alpha;
        if (fx[i] && fy[j]) begin
          alpha_acc[idx] = wa;
          for (int c = 0; c < 3; c++) color_acc[idx*3+c] = wa * ch[c];
        end else begin
          alpha_acc[idx] += wa;
          for (int c = 0; c < 3; c++) color_acc[idx*3+c] += wa * ch[c];
        end
        if (lx[i] && ly[j] && !emitted) begin
          asum = alpha_acc[idx];
          area = longint'(w) * h;
          for (int c = 0; c < 3; c++) begin
            csum = color_acc[idx*3+c];
            q[c] = asum == 0 ? 0 : (csum + asum / 2) / asum;
          end
          word.red = q[0][7:0];
          word.green = q[1][7:0];
          word.blue = q[2][7:0];
          csum = (asum + area / 2) / area;
          word.alpha = csum[7:0];
          word.last = (ox[i] == dw - 1) && (oy[j] == dh - 1);
          texel_q.push_back(word);
          emitted = 1'b1;
        end
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
      bank_sel = 32'((longint'(row_pos) * dh / h) & 1);
    end
  endtask

  // source driver
  always @(negedge clk) begin
    if (rst) begin
      src_ch.valid <= 1'b0;
    end else if (!src_ch.valid || src_fire) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        src_ch.valid <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        src_gap <= $urandom_range(0, 10);
        src_ch.valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        texel_t p;
        p = pixel_q.pop_front();
        src_ch.valid <= 1'b1;
        src_ch.src_red <= p.red;
        src_ch.src_green <= p.green;
        src_ch.src_blue <= p.blue;
        src_ch.src_alpha <= p.alpha;
      end else begin
        src_ch.valid <= 1'b0;
      end
    end
  end

  // result sink stalls
  always @(negedge clk) begin
    if (dst_gap > 0) begin
      dst_gap <= dst_gap - 1;
      dst_ch.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      dst_gap <= $urandom_range(0, 10);
      dst_ch.ready <= 1'b0;
    end else begin
      dst_ch.ready <= 1'b1;
    end
  end

  // accepted words on both sides
  always @(posedge clk) begin
    mip_word_t want;
    bit bad;
    src_fire <= src_ch.valid && src_ch.ready && !rst;
    if (!rst && src_ch.valid && src_ch.ready)
      accumulate_pixel({src_ch.src_red, src_ch.src_green, src_ch.src_blue, src_ch.src_alpha});
    if (!rst && dst_ch.valid && dst_ch.ready) begin
      if (texel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected texel %h %h %h %h last %b", dst_ch.out_red, dst_ch.out_green,
                   dst_ch.out_blue, dst_ch.out_alpha, dst_ch.frame_last);
      end else begin
        want = texel_q.pop_front();
        bad = (dst_ch.out_red !== want.red) || (dst_ch.out_green !== want.green) ||
              (dst_ch.out_blue !== want.blue) || (dst_ch.out_alpha !== want.alpha) ||
              (dst_ch.frame_last !== want.last);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("texel mismatch exp %h %h %h %h last %b got %h %h %h %h last %b",
                     want.red, want.green, want.blue, want.alpha, want.last,
                     dst_ch.out_red, dst_ch.out_green, dst_ch.out_blue, dst_ch.out_alpha,
                     dst_ch.frame_last);
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (src_ch.valid && src_ch.ready) || (dst_ch.valid && dst_ch.ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    if (idx == REG_SOURCE_WIDTH) width_reg = val & 13'h1FFF;
    else height_reg = val & 13'h1FFF;
    col_pos = 0;
    row_pos = 0;
    bank_sel = 0;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every pixel is sent and every texel is back, then let the datapath settle
  task automatic drain();
    do @(posedge clk);
    while (pixel_q.size() > 0 || src_ch.valid || texel_q.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_random(input int cnt);
    texel_t p;
    for (int i = 0; i < cnt; i++) begin
      p = $urandom;
      // some fully transparent pixels so zero alpha footprints happen
      if ($urandom_range(0, 5) == 0) p.alpha = 8'd0;
      pixel_q.push_back(p);
    end
  endtask

  task automatic frame(input int unsigned w, input int unsigned h, input int cnt);
    write_reg(REG_SOURCE_WIDTH, w);
    write_reg(REG_SOURCE_HEIGHT, h);
    push_random(cnt);
    drain();
  endtask

  // stimulus
  initial begin
    int unsigned w, h;
    int done_items;
    int cnt;
    src_ch.valid = 1'b0;
    src_ch.src_red = '0;
    src_ch.src_green = '0;
    src_ch.src_blue = '0;
    src_ch.src_alpha = '0;
    dst_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_SOURCE_WIDTH;
    cfg_data = '0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // extremes on a 2x2 frame, then an all transparent footprint
    write_reg(REG_SOURCE_WIDTH, 2);
    write_reg(REG_SOURCE_HEIGHT, 2);
    pixel_q.push_back({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    pixel_q.push_back({8'h00, 8'h00, 8'h00, 8'h00});
    pixel_q.push_back({8'hFF, 8'h00, 8'hFF, 8'h01});
    pixel_q.push_back({8'h00, 8'hFF, 8'h00, 8'hFE});
    repeat (4) pixel_q.push_back({8'hA5, 8'h5A, 8'hFF, 8'h00});
    drain();
    // odd size, all nine texels fold into one output texel
    frame(3, 3, 9);
    // zero acts as one
    frame(0, 0, 3);
    frame(5, 1, 5);
    frame(1, 7, 7);

    // random small frames, some partial or repeated
    done_items = 0;
    while (done_items < 250) begin
      w = $urandom_range(1, 9);
      h = $urandom_range(1, 9);
      case ($urandom_range(0, 3))
        0: cnt = int'($urandom_range(1, w * h));
        1: cnt = int'(2 * w * h);
        default: cnt = int'(w * h);
      endcase
      frame(w, h, cnt);
      done_items += cnt;
    end

    // largest sizes and values above the maximum, first rows only
    frame(4096, 1, 48);
    frame(8191, 2, 48);
    frame(1, 8191, 24);
    frame(3, 4096, 30);

    // last part without idling
    idle_en = 1'b0;
    frame(8, 6, 96);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/awhd_pkg.sv
src/awhd_if.sv
src/awhd_ram.sv
src/awhd_axis.sv
src/awhd_div.sv
src/alpha_weighted_half_downsample.sv
test/tb_alpha_weighted_half_downsample.sv
